>>> hw/rtl/tsd_pkg.sv
package tsd_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int TYPE_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 16;
  localparam int STAMP_W = 32;
  localparam int DIST_W  = 17;
  localparam int SPEED_W = 32;
  localparam int COUNT_W = 6;
  localparam int DIR_W   = 2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TYPE_W-1:0] REQ_DOWN = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_MOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_UP   = 2'd2;

  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR  = 1'd1;

  localparam logic [DIST_W-1:0]  MIN_DIST_RST = 17'd6554;
  localparam logic [STAMP_W-1:0] MAX_DUR_RST  = 32'd300000;

  localparam logic [COUNT_W-1:0] FINGERS_MAX = 6'd63;
  localparam logic [19:0]        US_PER_S    = 20'd1000000;

endpackage

>>> hw/rtl/touch_swipe_detector.sv
// Touch swipe detector.
// Input stream s_*: one touch event per item. s_tuser carries the event kind
// (down, move, up); s_tdata carries slot, x, y and microsecond stamp.
// Output stream m_*: one swipe result per qualifying finger-up. m_tuser is the
// direction, m_tdata holds speed and the finger count at lift time.
// Config channel cfg_*: index 0 min_distance, index 1 max_duration_us; always
// ready. It is to be written only while the block is idle; the user must keep
// to this, the block itself does not enforce it. Down, move, ignored events
// and ups on a free slot leave s_tready high. An up on an active slot without
// a swipe runs a memory read, 2-bit square digits, the square root and a
// threshold check. A swipe adds 4-bit multiply digits by 10^6, bit-serial
// division and an output step, after which m_tvalid rises. s_tready stays low
// through all of this; no new event is taken until the block is idle again.
// Results sit in an output register; the next event is taken while it waits.
// If a new result is ready while the receiver still stalls, the block holds
// it and keeps s_tready low until the output register frees up.
// Reset (rst, synchronous) clears slot states, the finger count, the output
// valid and restores register defaults. Start points are undefined until a
// down event writes them.
module touch_swipe_detector import tsd_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // slot, pos_x, pos_y, stamp_us, zero pad
  input  logic [TYPE_W-1:0]     s_tuser,   // req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // speed, finger_count, zero pad
  output logic [DIR_W-1:0]      m_tuser,   // direction
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = 2 * POS_W + STAMP_W;
  localparam int RAD_W = 34;
  localparam int REM_W = 19;
  localparam int PROD_W = 37;

  localparam int SQ_STEPS  = POS_W / 2;
  localparam int RT_STEPS  = RAD_W / 2;
  localparam int MUL_STEPS = 5;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_RT   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  function automatic logic [POS_W+1:0] dig_mul(input logic [POS_W-1:0] a,
                                               input logic [1:0] d);
    logic [POS_W+1:0] r;
    r = (d[0] ? {2'b00, a} : '0) + (d[1] ? {1'b0, a, 1'b0} : '0);
    return r;
  endfunction

  logic [2:0] state;
  logic [5:0] cnt;

  logic [DIST_W-1:0]  min_distance;
  logic [STAMP_W-1:0] max_duration_us;

  logic [SLOTS-1:0]   active;
  logic [COUNT_W-1:0] fingers;
  logic [COUNT_W-1:0] count_before;
  logic [ENT_W-1:0]   mem [SLOTS];
  logic [ENT_W-1:0]   rd_q;

  logic [POS_W-1:0]   lx, ly;
  logic [STAMP_W-1:0] lt;
  logic [STAMP_W-1:0] elapsed;
  logic [DIR_W-1:0]   dir;

  logic [POS_W-1:0]   mx, my;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [DIST_W-1:0]  root;
  logic [19:0]        kdig;
  logic [PROD_W-1:0]  prod;
  logic [STAMP_W-1:0] drem;

  logic               out_valid;
  logic [SPEED_W-1:0] out_speed;
  logic [COUNT_W-1:0] out_count;
  logic [DIR_W-1:0]   out_dir;

  logic [TYPE_W-1:0]  in_type;
  logic [SLOT_W-1:0]  in_slot;
  logic [POS_W-1:0]   in_x, in_y;
  logic [STAMP_W-1:0] in_t;
  logic [AW-1:0]      addr;
  logic               in_range;
  logic               acc;

  logic [POS_W:0]     dx, dy;
  logic [POS_W-1:0]   adx, ady;
  logic [DIR_W-1:0]   dir_next;
  logic [RAD_W-1:0]   rad_next;
  logic [REM_W+1:0]   rt_sh, rt_trial;
  logic [DIST_W+3:0]  mul_pp;
  logic [STAMP_W:0]   div_sh;
  logic               out_free;

  assign in_slot  = s_tdata[SLOT_W-1:0];
  assign in_x     = s_tdata[SLOT_W +: POS_W];
  assign in_y     = s_tdata[SLOT_W+POS_W +: POS_W];
  assign in_t     = s_tdata[SLOT_W+2*POS_W +: STAMP_W];
  assign in_type  = s_tuser;
  assign addr     = AW'(in_slot);
  assign in_range = (32'(in_slot) < 32'(SLOTS));

  assign s_tready  = (state == ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-SPEED_W-COUNT_W){1'b0}}, out_count, out_speed};
  assign m_tuser  = out_dir;
  assign out_free = !out_valid || m_tready;

  // displacement from the start point read out of the slot memory
  always_comb begin
    dx = {1'b0, lx} - {1'b0, rd_q[POS_W-1:0]};
    dy = {1'b0, ly} - {1'b0, rd_q[POS_W +: POS_W]};
    adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    if (adx > ady) begin
      dir_next = dx[POS_W] ? DIR_LEFT : DIR_RIGHT;
    end else begin
      dir_next = (!dy[POS_W] && (dy != '0)) ? DIR_DOWN : DIR_UP;
    end
  end

  // adx/ady stay put while busy; mx/my only feed the multiplier digits
  always_comb begin
    rad_next = {rad[RAD_W-3:0], 2'b00}
             + RAD_W'(dig_mul(adx, mx[POS_W-1 -: 2]))
             + RAD_W'(dig_mul(ady, my[POS_W-1 -: 2]));
    rt_sh    = {rem, rad[RAD_W-1 -: 2]};
    rt_trial = (REM_W+2)'({root, 2'b01});
    mul_pp   = root * kdig[19:16];
    div_sh   = {drem, prod[PROD_W-1]};
  end

  always_ff @(posedge clk) begin
    if (acc && in_range && (in_type == REQ_DOWN)) begin
      mem[addr] <= {in_t, in_y, in_x};
    end
    if (acc) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance    <= MIN_DIST_RST;
      max_duration_us <= MAX_DUR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_DIST: min_distance    <= cfg_data[DIST_W-1:0];
        CFG_MAX_DUR:  max_duration_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      active    <= '0;
      fingers   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc && in_range) begin
            lx <= in_x;
            ly <= in_y;
            lt <= in_t;
            if (in_type == REQ_DOWN) begin
              active[addr] <= 1'b1;
              if (fingers != FINGERS_MAX) begin
                fingers <= fingers + 1'b1;
              end
            end else if (in_type == REQ_UP) begin
              count_before <= fingers;
              if (fingers != '0) begin
                fingers <= fingers - 1'b1;
              end
              if (active[addr]) begin
                active[addr] <= 1'b0;
                state <= ST_RD;
              end
            end
          end
        end
        ST_RD: begin
          mx      <= adx;
          my      <= ady;
          dir     <= dir_next;
          elapsed <= lt - rd_q[2*POS_W +: STAMP_W];
          rad     <= '0;
          cnt     <= '0;
          state   <= ST_SQ;
        end
        ST_SQ: begin
          rad <= rad_next;
          mx  <= {mx[POS_W-3:0], 2'b00};
          my  <= {my[POS_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == 6'(SQ_STEPS-1)) begin
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
            state <= ST_RT;
          end
        end
        ST_RT: begin
          // one root bit per cycle, two radicand bits consumed
          if (rt_sh >= rt_trial) begin
            rem  <= REM_W'(rt_sh - rt_trial);
            root <= {root[DIST_W-2:0], 1'b1};
          end else begin
            rem  <= REM_W'(rt_sh);
            root <= {root[DIST_W-2:0], 1'b0};
          end
          rad <= {rad[RAD_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == 6'(RT_STEPS-1)) begin
            cnt   <= '0;
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if ((root > min_distance) && (elapsed != '0) && (elapsed < max_duration_us)) begin
            prod  <= '0;
            kdig  <= US_PER_S;
            state <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          prod <= {prod[PROD_W-5:0], 4'b0000} + PROD_W'(mul_pp);
          kdig <= {kdig[15:0], 4'b0000};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'(MUL_STEPS-1)) begin
            cnt   <= '0;
            drem  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring division; the dividend shifts out as quotient bits shift in
          if (div_sh >= {1'b0, elapsed}) begin
            drem <= STAMP_W'(div_sh - {1'b0, elapsed});
            prod <= {prod[PROD_W-2:0], 1'b1};
          end else begin
            drem <= div_sh[STAMP_W-1:0];
            prod <= {prod[PROD_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(DIV_STEPS-1)) begin
            cnt   <= '0;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_dir   <= dir;
            out_count <= count_before;
            out_speed <= (prod[PROD_W-1:SPEED_W] != '0) ? '1 : prod[SPEED_W-1:0];
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/tsd_checker.sv
module tsd_checker import tsd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [TYPE_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [DIR_W-1:0]      m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a new result only appears out of the busy phase of an up event
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a busy phase");

  // anything other than an up leaves the input ready for the next item
  a_quick_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != REQ_UP) |=> s_tready)
    else $error("non-up item stalled the input");

endmodule

bind touch_swipe_detector tsd_checker u_tsd_checker (.*);
